// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ESFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ESFP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/esfp_pkg.sv =====
`default_nettype none
package esfp_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Field names packed little-endian, first byte in the low bits.
    localparam logic [39:0] NAME_EVENT = 40'h74_6E_65_76_65;
    localparam logic [39:0] NAME_DATA  = 40'h00_61_74_61_64;
    localparam logic [39:0] NAME_ID    = 40'h00_00_00_64_69;

    localparam int NAME_MAX = 5;
    localparam int MSG_LEN  = 7;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        TK_EOL,
        TK_COLON,
        TK_SPACE,
        TK_OTHER
    } t_tok_class;

    typedef struct packed {
        t_tok_class cls;
        logic [7:0] data;
    } t_tok;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_NAME    = 3'd1,
        PH_COMMENT = 3'd2,
        PH_SPACE   = 3'd3,
        PH_VALUE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        FLD_IGNORED = 2'd0,
        FLD_EVENT   = 2'd1,
        FLD_DATA    = 2'd2,
        FLD_ID      = 2'd3
    } t_field;

    typedef enum logic [2:0] {
        K_TYPE_START = 3'd0,
        K_TYPE_BYTE  = 3'd1,
        K_DATA_BYTE  = 3'd2,
        K_DATA_END   = 3'd3,
        K_ID_START   = 3'd4,
        K_ID_BYTE    = 3'd5,
        K_DISPATCH   = 3'd6
    } t_kind;

    // Letters of "message" by position.
    function automatic logic [7:0] msg_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h6D;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h61;
            3'd5:    c = 8'h67;
            3'd6:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/esfp_front.sv =====
`default_nettype none
module esfp_front import esfp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_full,
    output logic            o_stall,
    output logic            o_push,
    output t_tok            o_tok
);

    logic r_after_cr;
    logic n_after_cr;
    logic accept;
    logic swallow;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    // LF directly after CR completes the same line end: drop it.
    assign swallow = (i_byte == CH_LF) && r_after_cr;
    assign o_push  = accept && !swallow;

    always_comb begin
        o_tok.data = i_byte;
        if (i_byte == CH_CR || i_byte == CH_LF) begin
            o_tok.cls = TK_EOL;
        end else if (i_byte == CH_COLON) begin
            o_tok.cls = TK_COLON;
        end else if (i_byte == CH_SPACE) begin
            o_tok.cls = TK_SPACE;
        end else begin
            o_tok.cls = TK_OTHER;
        end
    end

    always_comb begin
        n_after_cr = r_after_cr;
        if (accept) begin
            n_after_cr = swallow ? 1'b0 : (i_byte == CH_CR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_cr <= 1'b0;
        end else begin
            r_after_cr <= n_after_cr;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/esfp_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module esfp_queue import esfp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_tok i_tok,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_tok      o_tok
);

    t_tok              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_tok   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    `ESFP_NEVER(a_q_overfill, i_clk, i_rst_n, r_count > QCNT_W'(QDEPTH), "queue count over depth")
    `ESFP_NEVER(a_q_underrun, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `ESFP_NEVER(a_q_overrun, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")

endmodule
`default_nettype wire

// ===== rtl/core/esfp_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module esfp_back import esfp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire t_tok       i_tok,
    output logic            o_pop,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output logic [2:0]      o_out_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_is_message
);

    t_phase      r_phase,    n_phase;
    logic [39:0] r_name,     n_name;
    logic [2:0]  r_name_len, n_name_len;
    logic        r_too_long, n_too_long;
    t_field      r_field,    n_field;
    logic [2:0]  r_tmi,      n_tmi;
    logic        r_tim,      n_tim;

    logic        r_out_valid, n_out_valid;
    t_kind       r_out_kind,  n_out_kind;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic        r_out_msg,   n_out_msg;

    t_field      lookup;
    logic        emit;
    t_kind       e_kind;
    logic [7:0]  e_byte;
    logic        e_msg;
    logic [7:0]  b;

    assign b     = i_tok.data;
    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (r_too_long) begin
            lookup = FLD_IGNORED;
        end else if (r_name_len == 3'd5 && r_name == NAME_EVENT) begin
            lookup = FLD_EVENT;
        end else if (r_name_len == 3'd4 && r_name == NAME_DATA) begin
            lookup = FLD_DATA;
        end else if (r_name_len == 3'd2 && r_name == NAME_ID) begin
            lookup = FLD_ID;
        end else begin
            lookup = FLD_IGNORED;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_name     = r_name;
        n_name_len = r_name_len;
        n_too_long = r_too_long;
        n_field    = r_field;
        n_tmi      = r_tmi;
        n_tim      = r_tim;
        emit       = 1'b0;
        e_kind     = K_DISPATCH;
        e_byte     = 8'd0;
        e_msg      = 1'b0;

        if (i_tok.cls == TK_EOL) begin
            unique case (r_phase)
                PH_START: begin
                    emit   = 1'b1;
                    e_kind = K_DISPATCH;
                    e_msg  = r_tim;
                    n_tmi  = 3'd0;
                    n_tim  = 1'b1;
                end
                PH_NAME: begin
                    priority case (lookup)
                        FLD_DATA: begin
                            emit   = 1'b1;
                            e_kind = K_DATA_END;
                        end
                        FLD_EVENT: begin
                            emit   = 1'b1;
                            e_kind = K_TYPE_START;
                            n_tmi  = 3'd0;
                            n_tim  = 1'b1;
                        end
                        FLD_ID: begin
                            emit   = 1'b1;
                            e_kind = K_ID_START;
                        end
                        default: ;
                    endcase
                end
                PH_SPACE, PH_VALUE: begin
                    if (r_field == FLD_DATA) begin
                        emit   = 1'b1;
                        e_kind = K_DATA_END;
                    end
                end
                default: ;
            endcase
            n_phase    = PH_START;
            n_name     = '0;
            n_name_len = '0;
            n_too_long = 1'b0;
            n_field    = FLD_IGNORED;
        end else begin
            unique case (r_phase)
                PH_START, PH_NAME: begin
                    if (i_tok.cls == TK_COLON) begin
                        if (r_phase == PH_START) begin
                            n_phase = PH_COMMENT;
                        end else begin
                            n_phase = PH_SPACE;
                            n_field = lookup;
                            if (lookup == FLD_EVENT) begin
                                emit   = 1'b1;
                                e_kind = K_TYPE_START;
                                n_tmi  = 3'd0;
                                n_tim  = 1'b1;
                            end else if (lookup == FLD_ID) begin
                                emit   = 1'b1;
                                e_kind = K_ID_START;
                            end
                        end
                    end else begin
                        n_phase = PH_NAME;
                        if (r_name_len < 3'(NAME_MAX)) begin
                            n_name[{r_name_len, 3'b000} +: 8] = b;
                            n_name_len = r_name_len + 1'b1;
                        end else begin
                            n_too_long = 1'b1;
                        end
                    end
                end
                PH_SPACE, PH_VALUE: begin
                    n_phase = PH_VALUE;
                    // Drop one leading space right after the colon.
                    if (!(r_phase == PH_SPACE && i_tok.cls == TK_SPACE)) begin
                        unique case (r_field)
                            FLD_EVENT: begin
                                emit   = 1'b1;
                                e_kind = K_TYPE_BYTE;
                                e_byte = b;
                                if (r_tmi < 3'(MSG_LEN) && b == msg_char(r_tmi)) begin
                                    n_tmi = r_tmi + 1'b1;
                                    n_tim = (r_tmi == 3'(MSG_LEN - 1));
                                end else begin
                                    n_tmi = 3'(MSG_LEN);
                                    n_tim = 1'b0;
                                end
                            end
                            FLD_DATA: begin
                                emit   = 1'b1;
                                e_kind = K_DATA_BYTE;
                                e_byte = b;
                            end
                            FLD_ID: begin
                                emit   = 1'b1;
                                e_kind = K_ID_BYTE;
                                e_byte = b;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_msg   = r_out_msg;
        if (o_pop) begin
            n_out_valid = emit;
            n_out_kind  = e_kind;
            n_out_byte  = e_byte;
            n_out_msg   = e_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_name      <= '0;
            r_name_len  <= '0;
            r_too_long  <= 1'b0;
            r_field     <= FLD_IGNORED;
            r_tmi       <= '0;
            r_tim       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase    <= n_phase;
                r_name     <= n_name;
                r_name_len <= n_name_len;
                r_too_long <= n_too_long;
                r_field    <= n_field;
                r_tmi      <= n_tmi;
                r_tim      <= n_tim;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_msg  <= n_out_msg;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_byte   = r_out_byte;
    assign o_is_message = r_out_msg;

    `ESFP_NEVER(a_b_name_len, i_clk, i_rst_n, r_name_len > 3'(NAME_MAX), "name length over five")
    `ESFP_ASSERT(a_b_too_long, i_clk, i_rst_n, r_too_long |-> r_name_len == 3'(NAME_MAX), "long name flag without full name")
    `ESFP_ASSERT(a_b_marker_byte, i_clk, i_rst_n, (r_out_valid && (r_out_kind == K_TYPE_START || r_out_kind == K_DATA_END || r_out_kind == K_ID_START || r_out_kind == K_DISPATCH)) |-> r_out_byte == 8'd0, "marker carries a byte")

endmodule
`default_nettype wire

// ===== rtl/core/event_stream_field_parser_core.sv =====
`default_nettype none
// Event-stream field parser: takes server-sent-event text one byte per request and returns
// tagged results (type start/byte, data byte, data line end, id start/byte, dispatch with
// the is-message flag), zero or one result per byte. CR, LF and CR LF each end one line,
// also when the pair is split across requests. A byte is taken every cycle while the
// front is not stalled; the front normalizes line ends and classifies the byte, a
// four-entry queue decouples it from the back, and the back runs the line parser
// and owns the output register. A byte's result is presented at the earliest once the byte
// has been written into the queue at the accepting edge and then parsed from the queue head
// into the output register. Sustained rate is one byte per cycle, set by the back's parse
// step; i_out_stall only backs up the queue, and the input is stalled once the queue is full.
module event_stream_field_parser_core import esfp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_stream_valid,
    input  wire logic [7:0] i_stream_byte,
    output logic            o_stream_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_out_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_is_message
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_tok push_tok;
    t_tok head_tok;

    // Front: hold the CR state, drop an LF that completes a CR LF pair, classify the byte.
    esfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_stream_valid),
        .i_byte  (i_stream_byte),
        .i_full  (full),
        .o_stall (o_stream_stall),
        .o_push  (push),
        .o_tok   (push_tok)
    );

    // Queue: absorb output stalls so the front keeps taking bytes until the queue is full.
    esfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_tok   (head_tok)
    );

    // Back: advance the parser one token per cycle unless stalled; register the result.
    esfp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_tok        (head_tok),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_is_message (o_is_message)
    );

endmodule
`default_nettype wire

// ===== dv/event_stream_field_parser_core_tb.sv =====
module event_stream_field_parser_core_tb;
    import esfp_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT      = 2_000_000;
    localparam int REPORT_MAX   = 10;

    // Letters of the event type that counts as a plain message, first letter on top.
    localparam logic [55:0] MESSAGE_WORD = "message";

    // One output request as the block presents it.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       msg;
    } t_parse_out;

    localparam t_parse_out NO_OUT = '{K_TYPE_START, 8'h00, 1'b0};

    // One directed input request; rows with typed set carry their result by hand.
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        logic       fires;
        t_parse_out out;
    } t_stim_row;

    // Idle pattern of the two sides, walked through during the random part.
    typedef enum logic [2:0] {
        GAP_NONE,
        GAP_SENDER,
        GAP_RECEIVER,
        GAP_BOTH,
        GAP_HOLD
    } t_gap_mode;

    localparam t_stim_row DIRECTED_STIM [28] = '{
        // blank lines right after reset dispatch an empty type
        '{CH_CR,    1'b1, 1'b1, '{K_DISPATCH, 8'h00, 1'b1}},
        '{CH_LF,    1'b1, 1'b0, NO_OUT},                       // LF after CR: nothing
        '{CH_LF,    1'b1, 1'b1, '{K_DISPATCH, 8'h00, 1'b1}},
        // comment line with extreme bytes
        '{CH_COLON, 1'b1, 1'b0, NO_OUT},
        '{8'hFF,    1'b1, 1'b0, NO_OUT},
        '{8'h00,    1'b1, 1'b0, NO_OUT},
        '{CH_LF,    1'b1, 1'b0, NO_OUT},
        // id without a colon announces at the line end
        '{"i",      1'b0, 1'b0, NO_OUT},
        '{"d",      1'b0, 1'b0, NO_OUT},
        '{CH_CR,    1'b1, 1'b1, '{K_ID_START, 8'h00, 1'b0}},
        // data with one dropped space and extreme value bytes
        '{"d",      1'b0, 1'b0, NO_OUT},
        '{"a",      1'b0, 1'b0, NO_OUT},
        '{"t",      1'b0, 1'b0, NO_OUT},
        '{"a",      1'b0, 1'b0, NO_OUT},
        '{CH_COLON, 1'b1, 1'b0, NO_OUT},
        '{CH_SPACE, 1'b1, 1'b0, NO_OUT},
        '{8'hFF,    1'b1, 1'b1, '{K_DATA_BYTE, 8'hFF, 1'b0}},
        '{8'h00,    1'b1, 1'b1, '{K_DATA_BYTE, 8'h00, 1'b0}},
        '{CH_LF,    1'b1, 1'b1, '{K_DATA_END, 8'h00, 1'b0}},
        // event type that is not a message, then dispatch
        '{"e",      1'b0, 1'b0, NO_OUT},
        '{"v",      1'b0, 1'b0, NO_OUT},
        '{"e",      1'b0, 1'b0, NO_OUT},
        '{"n",      1'b0, 1'b0, NO_OUT},
        '{"t",      1'b0, 1'b0, NO_OUT},
        '{CH_COLON, 1'b0, 1'b0, NO_OUT},
        '{"x",      1'b0, 1'b0, NO_OUT},
        '{CH_LF,    1'b0, 1'b0, NO_OUT},
        '{CH_LF,    1'b0, 1'b0, NO_OUT}
    };

    // Drive every input to a known value from time zero.
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_stream_valid = 1'b0;
    logic [7:0] i_stream_byte  = 8'h00;
    logic       i_out_stall    = 1'b0;
    logic       o_stream_stall;
    logic       o_out_valid;
    logic [2:0] o_out_kind;
    logic [7:0] o_out_byte;
    logic       o_is_message;

    // Parser state mirrored from the byte stream.
    t_phase      line_ph;
    logic [39:0] name_word;
    logic [2:0]  name_len;
    logic        name_long;
    t_field      cur_field;
    logic        saw_cr;
    logic [2:0]  type_idx;
    logic        type_msg;

    t_parse_out  pending_outs[$];
    logic [7:0]  stream_q[$];
    t_gap_mode   gap_mode = GAP_NONE;
    int unsigned mismatch_count = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    event_stream_field_parser_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stream_valid (i_stream_valid),
        .i_stream_byte  (i_stream_byte),
        .o_stream_stall (o_stream_stall),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_kind     (o_out_kind),
        .o_out_byte     (o_out_byte),
        .o_is_message   (o_is_message)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    task automatic reset_parser();
        line_ph   = PH_START;
        name_word = '0;
        name_len  = '0;
        name_long = 1'b0;
        cur_field = FLD_IGNORED;
        saw_cr    = 1'b0;
        type_idx  = '0;
        type_msg  = 1'b1;
    endtask

    // Only the exact names act; anything longer than five bytes matches nothing.
    function automatic t_field name_field();
        if (name_long) return FLD_IGNORED;
        if (name_len == 3'd5 && name_word == NAME_EVENT) return FLD_EVENT;
        if (name_len == 3'd4 && name_word == NAME_DATA) return FLD_DATA;
        if (name_len == 3'd2 && name_word == NAME_ID) return FLD_ID;
        return FLD_IGNORED;
    endfunction

    // Store the next name byte, or flag the name as too long.
    task automatic push_name(input logic [7:0] b);
        if (name_len < 3'd5) begin
            name_word[8*name_len +: 8] = b;
            name_len++;
        end else begin
            name_long = 1'b1;
        end
    endtask

    // Start marker for event and id; a new event value restarts the type match.
    function automatic bit announce(input t_field fld, output t_parse_out r);
        r = NO_OUT;
        if (fld == FLD_EVENT) begin
            type_idx = '0;
            type_msg = 1'b1;
            r.kind   = K_TYPE_START;
            return 1'b1;
        end
        if (fld == FLD_ID) begin
            r.kind = K_ID_START;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Stream one value byte out; type bytes also advance the match against "message".
    function automatic bit take_value(input logic [7:0] b, output t_parse_out r);
        r      = NO_OUT;
        r.data = b;
        case (cur_field)
            FLD_EVENT: begin
                if (type_idx < 3'd7 && b == MESSAGE_WORD[8*(6-type_idx) +: 8]) begin
                    type_idx++;
                    type_msg = (type_idx == 3'd7);
                end else begin
                    type_idx = 3'd7;
                    type_msg = 1'b0;
                end
                r.kind = K_TYPE_BYTE;
                return 1'b1;
            end
            FLD_DATA: begin
                r.kind = K_DATA_BYTE;
                return 1'b1;
            end
            FLD_ID: begin
                r.kind = K_ID_BYTE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Advance the mirrored parser by one byte and give the result it causes, if any.
    task automatic parse_byte(input logic [7:0] b, output bit fired, output t_parse_out r);
        t_field fld;
        fired = 1'b0;
        r     = NO_OUT;
        // Swallow the LF of a CR LF pair, even across requests.
        if (b == CH_LF && saw_cr) begin
            saw_cr = 1'b0;
            return;
        end
        saw_cr = (b == CH_CR);
        if (b == CH_CR || b == CH_LF) begin
            case (line_ph)
                PH_START: begin
                    // Blank line: dispatch, then the type goes back to empty.
                    fired    = 1'b1;
                    r.kind   = K_DISPATCH;
                    r.msg    = type_msg;
                    type_idx = '0;
                    type_msg = 1'b1;
                end
                PH_NAME: begin
                    // Name without a colon: empty value.
                    fld = name_field();
                    if (fld == FLD_DATA) begin
                        fired  = 1'b1;
                        r.kind = K_DATA_END;
                    end else begin
                        fired = announce(fld, r);
                    end
                end
                PH_SPACE, PH_VALUE: begin
                    if (cur_field == FLD_DATA) begin
                        fired  = 1'b1;
                        r.kind = K_DATA_END;
                    end
                end
                default: ;
            endcase
            line_ph   = PH_START;
            name_word = '0;
            name_len  = '0;
            name_long = 1'b0;
            cur_field = FLD_IGNORED;
            return;
        end
        case (line_ph)
            PH_START: begin
                if (b == CH_COLON) begin
                    line_ph = PH_COMMENT;
                end else begin
                    line_ph = PH_NAME;
                    push_name(b);
                end
            end
            PH_NAME: begin
                if (b == CH_COLON) begin
                    cur_field = name_field();
                    line_ph   = PH_SPACE;
                    fired     = announce(cur_field, r);
                end else begin
                    push_name(b);
                end
            end
            PH_SPACE: begin
                // Drop one leading space of the value.
                line_ph = PH_VALUE;
                if (b != CH_SPACE) fired = take_value(b, r);
            end
            PH_VALUE: fired = take_value(b, r);
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Random stream text
    // ---------------------------------------------------------------------

    // Append one byte to the end of the random stream.
    task automatic add_byte(input logic [7:0] c);
        stream_q.insert(stream_q.size(), c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // Value byte: half printable, half anything but a line end.
    function automatic logic [7:0] value_char();
        logic [7:0] c;
        c = $urandom_range(1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(255));
        if (c == CH_CR || c == CH_LF) c = CH_COLON;
        return c;
    endfunction

    task automatic add_random_line();
        int pick;
        pick = $urandom_range(99);
        if (pick < 14) begin
            // blank line: nothing before the line end
        end else if (pick < 20) begin
            add_byte(CH_COLON);
            repeat ($urandom_range(0, 6)) add_byte(value_char());
        end else if (pick < 92) begin
            case ($urandom_range(9))
                0, 1, 2: add_text("event");
                3, 4, 5: add_text("data");
                6, 7:    add_text("id");
                8:       add_text("retry");
                default: begin
                    case ($urandom_range(3))
                        0: add_text("eventual");
                        1: add_text("dat");
                        2: add_text("idd");
                        default: begin
                            repeat ($urandom_range(1, 7))
                                add_byte(8'($urandom_range(97, 122)));
                        end
                    endcase
                end
            endcase
            if ($urandom_range(9) != 0) begin
                add_byte(CH_COLON);
                if ($urandom_range(1) != 0) add_byte(CH_SPACE);
                case ($urandom_range(5))
                    0: add_text("message");
                    1: add_text("messages");
                    2: add_text("mess");
                    default: repeat ($urandom_range(0, 8)) add_byte(value_char());
                endcase
            end
        end else begin
            // raw noise, line ends and colons included
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
        end
        case ($urandom_range(2))
            0: add_byte(CH_LF);
            1: add_byte(CH_CR);
            default: begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------

    // Idle percentage of one side in the current mode.
    function automatic int unsigned gap_pct(input t_gap_mode m, input bit sender_side);
        case (m)
            GAP_SENDER:   return sender_side ? 79 : 0;
            GAP_RECEIVER: return sender_side ? 0 : 79;
            GAP_BOTH:     return 20;
            default:      return 0;
        endcase
    endfunction

    // Offer one input request, hold it until accepted, then log what it should produce.
    // Called and returning at a rising edge; each edge gets at most one assignment to valid.
    task automatic send_byte(input logic [7:0] b, input bit typed, input bit t_fires,
                             input t_parse_out t_out);
        bit         taken;
        bit         fired;
        t_parse_out pred;
        while ($urandom_range(99) < gap_pct(gap_mode, 1'b1)) begin
            i_stream_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_stream_valid <= 1'b1;
        i_stream_byte  <= b;
        taken = 1'b0;
        // Sample the stall away from the edge, where it is settled.
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stream_stall;
            @(posedge i_clk);
        end
        parse_byte(b, fired, pred);
        if (typed) begin
            if (t_fires) pending_outs.insert(pending_outs.size(), t_out);
        end else if (fired) begin
            pending_outs.insert(pending_outs.size(), pred);
        end
    endtask

    // Output stall: random per mode, plus one long hold that backs the block up.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (gap_mode == GAP_HOLD && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < gap_pct(gap_mode, 1'b0));
        end
    end

    // Compare each accepted output request with the oldest expected one.
    always @(negedge i_clk) begin
        t_parse_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outs.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected result: kind %0d byte %02h msg %0d",
                             o_out_kind, o_out_byte, o_is_message);
                mismatch_count++;
            end else begin
                want = pending_outs.pop_front();
                if (o_out_kind !== want.kind || o_out_byte !== want.data ||
                    o_is_message !== want.msg) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("mismatch: kind %0d byte %02h msg %0d, expected %0d %02h %0d",
                                 o_out_kind, o_out_byte, o_is_message,
                                 want.kind, want.data, want.msg);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial begin
        int n_rand;
        reset_parser();
        while (stream_q.size() < RANDOM_ITEMS) add_random_line();
        n_rand = stream_q.size();

        // Hold reset, then release.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_STIM[i])
            send_byte(DIRECTED_STIM[i].b, DIRECTED_STIM[i].typed, DIRECTED_STIM[i].fires,
                      DIRECTED_STIM[i].out);

        // Advance through the idle modes in equal slices of the random stream.
        for (int k = 0; k < n_rand; k++) begin
            gap_mode = t_gap_mode'(k * 5 / n_rand);
            send_byte(stream_q[k], 1'b0, 1'b0, NO_OUT);
        end
        i_stream_valid <= 1'b0;
        gap_mode = GAP_NONE;

        // Drain what is still in flight, then watch for strays.
        while (pending_outs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
